// ===== sv/integer_day_linear_resampler_macros.svh =====
// assertion macros for the day resampler checker
`ifndef INTEGER_DAY_LINEAR_RESAMPLER_MACROS_SVH
`define INTEGER_DAY_LINEAR_RESAMPLER_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define IDLR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define IDLR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/idlr_pkg.sv =====
package idlr_pkg;

    localparam int TIME_W        = 32;
    localparam int VALUE_W       = 32;
    localparam int DAY_IDX_W     = 16;
    localparam int PROD_W        = 2 * TIME_W;
    localparam int MAX_RESULTS   = 16;
    localparam int MAX_DAYS_DEF  = 15;
    localparam int TIME_FRAC_DEF = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_START,
        ST_MUL,
        ST_DIV,
        ST_PUSH,
        ST_TAIL
    } t_state;

    typedef enum logic {
        KIND_HELD,
        KIND_LINE
    } t_kind;

    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] mag;
        logic [TIME_W-1:0] num;
        logic [TIME_W-1:0] bias;
    } t_mul_req;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [TIME_W-1:0] divisor;
    } t_div_req;

endpackage

// ===== sv/idlr_in_if.sv =====
interface idlr_in_if;
    import idlr_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [TIME_W-1:0]         sample_time;
    logic signed [VALUE_W-1:0] sample_value;
    logic                      first_sample;
    logic                      last_sample;

    modport source (
        output valid, sample_time, sample_value, first_sample, last_sample,
        input  ready
    );

    modport sink (
        input  valid, sample_time, sample_value, first_sample, last_sample,
        output ready
    );
endinterface

// ===== sv/idlr_out_if.sv =====
interface idlr_out_if;
    import idlr_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [DAY_IDX_W-1:0]      day_index;
    logic signed [VALUE_W-1:0] day_value;
    logic                      run_end;
    logic                      gap_overflow;

    modport source (
        output valid, day_index, day_value, run_end, gap_overflow,
        input  ready
    );

    modport sink (
        input  valid, day_index, day_value, run_end, gap_overflow,
        output ready
    );
endinterface

// ===== sv/idlr_mul.sv =====
module idlr_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  idlr_pkg::t_mul_req          i_req,
    output logic                        o_done,
    output logic [idlr_pkg::PROD_W-1:0] o_product
);
    import idlr_pkg::*;

    localparam int STEPS = TIME_W;
    localparam int CNT_W = $clog2(STEPS);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [TIME_W-1:0] r_mag, r_hi, r_lo, n_hi, n_lo;
    logic [TIME_W:0]   w_sum;

    // one multiplier bit per cycle, bias preloaded into the high half
    always_comb begin
        w_sum  = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mag} : '0);
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        n_hi   = r_hi;
        n_lo   = r_lo;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_hi   = i_req.bias;
            n_lo   = i_req.num;
        end else if (r_busy) begin
            n_hi  = w_sum[TIME_W:1];
            n_lo  = {w_sum[0], r_lo[TIME_W-1:1]};
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi <= n_hi;
        r_lo <= n_lo;
        if (i_req.start) begin
            r_mag <= i_req.mag;
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_hi, r_lo};
endmodule

// ===== sv/idlr_div.sv =====
module idlr_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  idlr_pkg::t_div_req          i_req,
    output logic                        o_done,
    output logic [idlr_pkg::TIME_W-1:0] o_quotient
);
    import idlr_pkg::*;

    localparam int STEPS = TIME_W;
    localparam int CNT_W = $clog2(STEPS);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [TIME_W-1:0] r_den, r_rem, r_lo, n_rem, n_lo;
    logic [TIME_W:0]   w_shift, w_trial;
    logic              w_ge;

    // restoring division, one quotient bit per cycle; the high half of the
    // dividend is always below the divisor so the quotient fits one word
    always_comb begin
        w_shift = {r_rem, r_lo[TIME_W-1]};
        w_trial = w_shift - {1'b0, r_den};
        w_ge    = (w_shift >= {1'b0, r_den});
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_rem   = r_rem;
        n_lo    = r_lo;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = i_req.dividend[PROD_W-1:TIME_W];
            n_lo   = i_req.dividend[TIME_W-1:0];
        end else if (r_busy) begin
            n_rem = w_ge ? w_trial[TIME_W-1:0] : w_shift[TIME_W-1:0];
            n_lo  = {r_lo[TIME_W-2:0], w_ge};
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_lo  <= n_lo;
        if (i_req.start) begin
            r_den <= i_req.divisor;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_lo;
endmodule

// ===== sv/integer_day_linear_resampler.sv =====
// a first-sample value passes from the accept through the decide and push states into the
// output register; an interpolated day passes through the start, multiply, divide and push
// states, and a ceil day is pushed from the tail state after the last interpolated day, or
// after the decide state when there is none; one item in flight, the 32-step bit-serial
// multiplier and divider set the per-day cost, and a push waits while the output is stalled
// reset: synchronous active low, clears sequencer, output valid and previous sample
module integer_day_linear_resampler #(
    parameter int MAX_DAYS_PER_STEP = idlr_pkg::MAX_DAYS_DEF,
    parameter int TIME_FRAC_BITS    = idlr_pkg::TIME_FRAC_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    idlr_in_if.sink           i_smp,
    idlr_out_if.source        o_day
);
    import idlr_pkg::*;

    // whole-day part of a time word
    localparam int DAY_W   = TIME_W - TIME_FRAC_BITS;
    // results per item are capped, one slot is kept for the ceil day
    localparam int DAY_CAP = (MAX_DAYS_PER_STEP < MAX_RESULTS - 1) ?
                             MAX_DAYS_PER_STEP : MAX_RESULTS - 1;
    localparam int LEFT_W  = $clog2(DAY_CAP + 1);

    // sequencer
    t_state r_state, n_state;

    // stored previous sample and series flag
    logic [TIME_W-1:0]  r_prev_time;
    logic [VALUE_W-1:0] r_prev_value;
    logic               r_series_open;

    // current item
    logic [TIME_W-1:0]  r_cur_time;
    logic [VALUE_W-1:0] r_cur_value;
    logic               r_first;
    logic               r_last;

    // per-item bookkeeping
    logic               r_ceil;      // ceil day still to be sent
    logic               r_gap;       // days of this item were cut
    logic [LEFT_W-1:0]  r_left;      // interpolated days still to be sent
    logic [DAY_W:0]     r_day;       // day of the result being built
    t_kind              r_kind;
    logic               r_neg;       // line slopes down

    // serial units
    t_mul_req           r_mul_req;
    t_div_req           r_div_req;
    logic               w_mul_done, w_div_done;
    logic [PROD_W-1:0]  w_product;
    logic [TIME_W-1:0]  w_quo;

    // output register
    logic                 r_out_valid;
    logic [DAY_IDX_W-1:0] r_out_index;
    logic [VALUE_W-1:0]   r_out_value;
    logic                 r_out_end;
    logic                 r_out_gap;

    // decode of the current item against the previous sample
    logic [DAY_W-1:0]   w_cur_fday, w_prev_fday, w_count;
    logic               w_whole, w_later, w_open_new, w_over;
    logic [LEFT_W-1:0]  w_count_cut;
    logic [VALUE_W:0]   w_diff, w_neg_diff;
    logic [TIME_W-1:0]  w_mag, w_num, w_den;
    logic [VALUE_W-1:0] w_line;
    logic [TIME_W:0]    w_day_ext;
    logic               w_slot_free;

    // strobes from the output decode
    logic w_accept, w_mul_go, w_div_go, w_push, w_finish;

    assign w_cur_fday  = r_cur_time[TIME_W-1:TIME_FRAC_BITS];
    assign w_prev_fday = r_prev_time[TIME_W-1:TIME_FRAC_BITS];
    assign w_whole     = (r_cur_time[TIME_FRAC_BITS-1:0] == '0);
    assign w_later     = (r_cur_time > r_prev_time);
    assign w_open_new  = r_first || !r_series_open;
    // only used when time went up, so the day count cannot wrap
    assign w_count     = w_cur_fday - w_prev_fday;
    assign w_over      = (w_count > DAY_W'(DAY_CAP));
    assign w_count_cut = w_over ? LEFT_W'(DAY_CAP) : w_count[LEFT_W-1:0];

    // slope magnitude and sign, one bit wider to hold any difference
    assign w_diff     = {r_cur_value[VALUE_W-1], r_cur_value}
                      - {r_prev_value[VALUE_W-1], r_prev_value};
    assign w_neg_diff = (VALUE_W + 1)'(0) - w_diff;
    assign w_mag      = w_diff[VALUE_W] ? w_neg_diff[VALUE_W-1:0] : w_diff[VALUE_W-1:0];

    // distance of the day from the previous sample, and the span of the step
    assign w_num = {r_day[DAY_W-1:0], {TIME_FRAC_BITS{1'b0}}} - r_prev_time;
    assign w_den = r_cur_time - r_prev_time;

    // rounded quotient is at most the magnitude, so the line never leaves its ends
    assign w_line = r_neg ? (r_prev_value - w_quo) : (r_prev_value + w_quo);

    // day number extended so its low bits can always be taken
    assign w_day_ext   = {{(TIME_W - DAY_W){1'b0}}, r_day};
    assign w_slot_free = !r_out_valid || o_day.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_smp.valid) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (w_open_new) begin
                    n_state = ST_PUSH;
                end else if (w_later && (w_count != '0)) begin
                    n_state = ST_START;
                end else begin
                    n_state = ST_TAIL;
                end
            end
            ST_START: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                if (w_mul_done) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (w_slot_free) begin
                    if ((r_kind == KIND_LINE) && (r_left != LEFT_W'(1))) begin
                        n_state = ST_START;
                    end else begin
                        n_state = ST_TAIL;
                    end
                end
            end
            ST_TAIL: begin
                n_state = r_ceil ? ST_PUSH : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state decode
    always_comb begin
        w_accept = 1'b0;
        w_mul_go = 1'b0;
        w_div_go = 1'b0;
        w_push   = 1'b0;
        w_finish = 1'b0;
        case (r_state)
            ST_IDLE:  w_accept = i_smp.valid;
            ST_START: w_mul_go = 1'b1;
            ST_MUL:   w_div_go = w_mul_done;
            ST_PUSH:  w_push   = w_slot_free;
            ST_TAIL:  w_finish = !r_ceil;
            default: begin
                w_accept = 1'b0;
            end
        endcase
    end

    assign i_smp.ready = (r_state == ST_IDLE);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_out_valid   <= 1'b0;
            r_series_open <= 1'b0;
            r_prev_time   <= '0;
            r_prev_value  <= '0;
            r_mul_req     <= '0;
            r_div_req     <= '0;
        end else begin
            r_state <= n_state;

            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (o_day.ready) begin
                r_out_valid <= 1'b0;
            end

            // the item becomes the previous sample once all its results are out
            if (w_finish) begin
                r_prev_time   <= r_cur_time;
                r_prev_value  <= r_cur_value;
                r_series_open <= !r_last;
            end

            r_mul_req.start <= w_mul_go;
            if (w_mul_go) begin
                r_mul_req.mag  <= w_mag;
                r_mul_req.num  <= w_num;
                // half the span is added ahead of the divide for round to nearest
                r_mul_req.bias <= {1'b0, w_den[TIME_W-1:1]};
            end

            r_div_req.start <= w_div_go;
            if (w_div_go) begin
                r_div_req.dividend <= w_product;
                r_div_req.divisor  <= w_den;
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cur_time  <= i_smp.sample_time;
            r_cur_value <= i_smp.sample_value;
            r_first     <= i_smp.first_sample;
            r_last      <= i_smp.last_sample;
        end

        if (r_state == ST_DECIDE) begin
            r_ceil <= r_last && !w_whole;
            r_gap  <= !w_open_new && w_later && w_over;
            r_left <= w_count_cut;
            if (w_open_new) begin
                r_kind <= KIND_HELD;
                r_day  <= (DAY_W + 1)'(w_cur_fday);
            end else begin
                r_kind <= KIND_LINE;
                r_day  <= (DAY_W + 1)'(w_prev_fday) + (DAY_W + 1)'(1);
            end
        end

        if (w_mul_go) begin
            r_neg <= w_diff[VALUE_W];
        end

        if (w_push) begin
            r_out_index <= w_day_ext[DAY_IDX_W-1:0];
            r_out_gap   <= r_gap;
            if (r_kind == KIND_LINE) begin
                r_out_value <= w_line;
                r_out_end   <= (r_left == LEFT_W'(1)) && !r_ceil;
                r_left      <= r_left - LEFT_W'(1);
                r_day       <= r_day + (DAY_W + 1)'(1);
            end else begin
                r_out_value <= r_cur_value;
                r_out_end   <= !r_ceil;
            end
        end

        // ceil day of the final sample, its own value one day past floor
        if ((r_state == ST_TAIL) && r_ceil) begin
            r_ceil <= 1'b0;
            r_kind <= KIND_HELD;
            r_day  <= (DAY_W + 1)'(w_cur_fday) + (DAY_W + 1)'(1);
        end
    end

    idlr_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (r_mul_req),
        .o_done    (w_mul_done),
        .o_product (w_product)
    );

    idlr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (r_div_req),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign o_day.valid        = r_out_valid;
    assign o_day.day_index    = r_out_index;
    assign o_day.day_value    = r_out_value;
    assign o_day.run_end      = r_out_end;
    assign o_day.gap_overflow = r_out_gap;
endmodule

// ===== sv/idlr_chk.sv =====
`include "integer_day_linear_resampler_macros.svh"

module idlr_chk (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_in_valid,
    input logic                                   i_in_ready,
    input logic                                   i_out_valid,
    input logic                                   i_out_ready,
    input logic [idlr_pkg::DAY_IDX_W-1:0]         i_out_index,
    input logic signed [idlr_pkg::VALUE_W-1:0]    i_out_value,
    input logic                                   i_out_end,
    input logic                                   i_out_gap
);
    // stalled result keeps its payload
    `IDLR_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_index) && $stable(i_out_value) && $stable(i_out_end) && $stable(i_out_gap), "stalled result changed")

    // one item at a time: no second accept right after one
    `IDLR_ASSERT_NEXT(a_one_item, i_in_valid && i_in_ready, !i_in_ready, "ready high right after an accept")

    // while an item still owes results the input stays closed
    `IDLR_ASSERT_SAME(a_run_busy, i_out_valid && i_out_ready && !i_out_end, !i_in_ready, "input open in the middle of a run")
endmodule

bind integer_day_linear_resampler idlr_chk u_idlr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp.valid),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_day.valid),
    .i_out_ready (o_day.ready),
    .i_out_index (o_day.day_index),
    .i_out_value (o_day.day_value),
    .i_out_end   (o_day.run_end),
    .i_out_gap   (o_day.gap_overflow)
);
